/* rtl/wwdm_pkg.sv */
// Shared types, codes and character helpers of the whole-word dictionary matcher.
package wwdm_pkg;

    localparam logic [2:0] REQ_WORD_CHAR = 3'd0;
    localparam logic [2:0] REQ_COMMIT    = 3'd1;
    localparam logic [2:0] REQ_REMOVE    = 3'd2;
    localparam logic [2:0] REQ_TEXT_CHAR = 3'd3;
    localparam logic [2:0] REQ_TEXT_END  = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_EMPTY     = 3'd1;
    localparam logic [2:0] STAT_DUPLICATE = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_TOO_LONG  = 3'd4;
    localparam logic [2:0] STAT_BAD_INDEX = 3'd5;

    localparam logic KIND_MASK   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [15:0] CH_UPPER_A   = 16'h0041;
    localparam logic [15:0] CH_UPPER_Z   = 16'h005A;
    localparam logic [15:0] CH_LOWER_A   = 16'h0061;
    localparam logic [15:0] CH_LOWER_Z   = 16'h007A;
    localparam logic [15:0] CH_DIGIT_0   = 16'h0030;
    localparam logic [15:0] CH_DIGIT_9   = 16'h0039;
    localparam logic [15:0] CH_UNDERLINE = 16'h005F;
    localparam logic [15:0] CH_WIDE      = 16'h0080;
    localparam logic [15:0] CH_SPACE     = 16'h0020;
    localparam logic [15:0] CH_TAB       = 16'h0009;
    localparam logic [15:0] CH_CR        = 16'h000D;
    localparam logic [15:0] CASE_OFFSET  = 16'h0020;

    localparam int LEN_W = 6;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        list_select;
        logic [15:0] code_unit;
        logic [5:0]  entry_index;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] code_unit_out;
        logic        protected_flag;
        logic [2:0]  status;
        logic [6:0]  entry_count;
        logic        last;
    } rsp_t;

    function automatic logic [15:0] fold(input logic [15:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    function automatic logic is_space(input logic [15:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_word(input logic [15:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || c == CH_UNDERLINE || c >= CH_WIDE;
    endfunction

endpackage

/* rtl/wwdm_req_if.sv */
// Request channel interface: valid, ready and one request word.
interface wwdm_req_if;
    import wwdm_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/wwdm_rsp_if.sv */
// Result channel interface: valid, ready and one result word.
interface wwdm_rsp_if;
    import wwdm_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/wwdm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wwdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/wwdm_cmp.sv */
// Shared word compare unit: case-folded equality of the first len code units.
module wwdm_cmp #(
    parameter int MAX_WORD_LEN = 32
) (
    input  logic [16*MAX_WORD_LEN-1:0] chars_a,
    input  logic [16*MAX_WORD_LEN-1:0] chars_b,
    input  logic [5:0]                 len,
    output logic                       eq
);
    import wwdm_pkg::*;

    logic [MAX_WORD_LEN-1:0] mism;

    always_comb
    begin
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            mism[k] = (k < len) &&
                      (fold(chars_a[16*k +: 16]) != fold(chars_b[16*k +: 16]));
        end
    end

    assign eq = ~|mism;
endmodule

/* rtl/whole_word_dictionary_matcher.sv */
// Top level of the whole-word dictionary matcher: sequencer, staging, text window.
//
//  channel | dir | handshake         | word
//  req     | in  | req.valid/ready   | req_type, list_select, code_unit, entry_index
//  rsp     | out | rsp.valid/ready   | result_kind, code_unit_out, protected_flag,
//          |     |                   | status, entry_count, last
//
// Work per request: commit scans every stored word of the list; remove
// moves each word behind the removed one down a row; a text char can scan
// every stored word; text end may do so for each held unit.
// The loop is the dictionary scan: for each row of the word RAM, the address
// is set, then the registered data goes into the shared compare unit.
// Reset: rst_n clears counts, staging and run state at once; the word RAM
// holds no valid bits and needs no clearing pass.
// Stalls: a result waits in the output register; req.ready is high only
// while the sequencer idles, and the sequencer holds when it must emit
// into a full output register.
module whole_word_dictionary_matcher #(
    parameter int MAX_WORDS    = 64,
    parameter int MAX_WORD_LEN = 32,
    parameter int LIST_COUNT   = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    wwdm_req_if.sink   req,
    wwdm_rsp_if.source rsp
);
    import wwdm_pkg::*;

    localparam int WIN    = MAX_WORD_LEN + 1;
    localparam int WFW    = $clog2(WIN + 1);
    localparam int CW     = $clog2(MAX_WORDS + 1);
    localparam int DEPTH  = LIST_COUNT * MAX_WORDS;
    localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CHAR_W = 16 * MAX_WORD_LEN;
    localparam int ROW_W  = LEN_W + CHAR_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DUP_RD, ST_DUP_CHK, ST_RM_RD, ST_RM_WR,
        ST_HEAD, ST_M_RD, ST_M_CHK, ST_EMIT_MK, ST_EMIT_ST
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            list_reg, list_next;
    logic            text_list_reg, text_list_next;
    logic [5:0]      len_reg, len_next;
    logic [5:0]      best_reg, best_next;
    logic [2:0]      status_reg, status_next;
    logic            flag_reg, flag_next;
    logic            at_end_reg, at_end_next;
    logic [CW-1:0]   count_reg [LIST_COUNT];
    logic [CW-1:0]   count_next [LIST_COUNT];
    logic [5:0]      fill_reg, fill_next;
    logic [5:0]      trim_reg, trim_next;
    logic            ovf_reg, ovf_next;
    logic [WFW-1:0]  win_fill_reg, win_fill_next;
    logic [5:0]      run_rem_reg, run_rem_next;
    logic            prev_word_reg, prev_word_next;
    logic            active_reg, active_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_data_reg, out_data_next;
    logic [15:0]     stage_reg [MAX_WORD_LEN];
    logic [15:0]     stage_next [MAX_WORD_LEN];
    logic [15:0]     win_reg [WIN];
    logic [15:0]     win_next [WIN];

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [ROW_W-1:0]  ram_wdata, ram_rdata;
    logic [5:0]        rd_len;
    logic [CHAR_W-1:0] stage_vec, win_vec, cmp_b;
    logic [5:0]        cmp_len;
    logic              cmp_eq;
    logic              out_free;
    logic              lsel;
    logic [15:0]       win_at_len;
    logic [15:0]       cu_in;

    function automatic logic [AW-1:0] row(input logic l, input logic [CW-1:0] e);
        return AW'(l) * AW'(MAX_WORDS) + AW'(e);
    endfunction

    assign rd_len   = ram_rdata[ROW_W-1 -: LEN_W];
    assign out_free = !out_valid_reg || rsp.ready;
    assign lsel     = (int'(req.data.list_select) < LIST_COUNT) ? req.data.list_select : 1'b0;
    assign cu_in    = req.data.code_unit;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            stage_vec[16*k +: 16] = stage_reg[k];
            win_vec[16*k +: 16]   = win_reg[k];
        end
        win_at_len = win_reg[0];
        for (int k = 0; k < WIN; k++)
        begin
            if (k == rd_len)
            begin
                win_at_len = win_reg[k];
            end
        end
    end

    // Matching compares against the window, commit against the staging word.
    assign cmp_b   = (state_reg == ST_M_CHK) ? win_vec : stage_vec;
    assign cmp_len = (state_reg == ST_M_CHK) ? rd_len : len_reg;

    wwdm_cmp #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_cmp (
        .chars_a (ram_rdata[CHAR_W-1:0]),
        .chars_b (cmp_b),
        .len     (cmp_len),
        .eq      (cmp_eq)
    );

    wwdm_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [WFW-1:0] f;
        logic           sp;
        logic           ok;
        f              = '0;
        sp             = 1'b0;
        ok             = 1'b0;
        state_next     = state_reg;
        idx_next       = idx_reg;
        list_next      = list_reg;
        text_list_next = text_list_reg;
        len_next       = len_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        flag_next      = flag_reg;
        at_end_next    = at_end_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        trim_next      = trim_reg;
        ovf_next       = ovf_reg;
        win_fill_next  = win_fill_reg;
        run_rem_next   = run_rem_reg;
        prev_word_next = prev_word_reg;
        active_next    = active_reg;
        stage_next     = stage_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = row(list_reg, idx_reg);
        ram_wdata      = ram_rdata;
        ram_raddr      = row(list_reg, idx_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.data.req_type)
                        REQ_WORD_CHAR:
                        begin
                            sp = is_space(cu_in);
                            if (!(fill_reg == 6'd0 && sp))
                            begin
                                if (fill_reg < MAX_WORD_LEN)
                                begin
                                    for (int k = 0; k < MAX_WORD_LEN; k++)
                                    begin
                                        if (k == fill_reg)
                                        begin
                                            stage_next[k] = cu_in;
                                        end
                                    end
                                    if (!sp)
                                    begin
                                        trim_next = fill_reg + 6'd1;
                                    end
                                end
                                else if (!sp)
                                begin
                                    ovf_next = 1'b1;
                                end
                                if (fill_reg != 6'd63)
                                begin
                                    fill_next = fill_reg + 6'd1;
                                end
                            end
                        end
                        REQ_COMMIT:
                        begin
                            // Clear staging now; the characters stay for the scan.
                            list_next = lsel;
                            len_next  = trim_reg;
                            fill_next = '0;
                            trim_next = '0;
                            ovf_next  = 1'b0;
                            idx_next  = '0;
                            if (ovf_reg)
                            begin
                                status_next = STAT_TOO_LONG;
                                state_next  = ST_EMIT_ST;
                            end
                            else if (trim_reg == 6'd0)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = ST_EMIT_ST;
                            end
                            else
                            begin
                                state_next = ST_DUP_RD;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            list_next = lsel;
                            if (req.data.entry_index < count_reg[lsel])
                            begin
                                idx_next   = CW'(req.data.entry_index);
                                state_next = ST_RM_RD;
                            end
                            else
                            begin
                                status_next = STAT_BAD_INDEX;
                                state_next  = ST_EMIT_ST;
                            end
                        end
                        REQ_TEXT_CHAR:
                        begin
                            f = win_fill_reg;
                            if (!active_reg)
                            begin
                                active_next    = 1'b1;
                                text_list_next = lsel;
                                run_rem_next   = '0;
                                prev_word_next = 1'b0;
                                f              = '0;
                            end
                            if (f < WIN)
                            begin
                                for (int k = 0; k < WIN; k++)
                                begin
                                    if (k == f)
                                    begin
                                        win_next[k] = cu_in;
                                    end
                                end
                                f = f + WFW'(1);
                            end
                            win_fill_next = f;
                            if (f >= WIN)
                            begin
                                at_end_next = 1'b0;
                                state_next  = ST_HEAD;
                            end
                        end
                        REQ_TEXT_END:
                        begin
                            if (active_reg)
                            begin
                                if (win_fill_reg == '0)
                                begin
                                    active_next    = 1'b0;
                                    run_rem_next   = '0;
                                    prev_word_next = 1'b0;
                                end
                                else
                                begin
                                    at_end_next = 1'b1;
                                    state_next  = ST_HEAD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DUP_RD:
            begin
                if (idx_reg < count_reg[list_reg])
                begin
                    state_next = ST_DUP_CHK;
                end
                else if (count_reg[list_reg] >= MAX_WORDS)
                begin
                    status_next = STAT_FULL;
                    state_next  = ST_EMIT_ST;
                end
                else
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = row(list_reg, count_reg[list_reg]);
                    ram_wdata              = {len_reg, stage_vec};
                    count_next[list_reg]   = count_reg[list_reg] + CW'(1);
                    status_next            = STAT_OK;
                    state_next             = ST_EMIT_ST;
                end
            end
            ST_DUP_CHK:
            begin
                if (rd_len == len_reg && cmp_eq)
                begin
                    status_next = STAT_DUPLICATE;
                    state_next  = ST_EMIT_ST;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_DUP_RD;
                end
            end
            ST_RM_RD:
            begin
                // Close up: copy the row behind down onto this one.
                ram_raddr = row(list_reg, idx_reg + CW'(1));
                if (idx_reg + CW'(1) < count_reg[list_reg])
                begin
                    state_next = ST_RM_WR;
                end
                else
                begin
                    count_next[list_reg] = count_reg[list_reg] - CW'(1);
                    status_next          = STAT_OK;
                    state_next           = ST_EMIT_ST;
                end
            end
            ST_RM_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_reg + CW'(1);
                state_next = ST_RM_RD;
            end
            ST_HEAD:
            begin
                if (run_rem_reg != 6'd0)
                begin
                    flag_next    = 1'b1;
                    run_rem_next = run_rem_reg - 6'd1;
                    state_next   = ST_EMIT_MK;
                end
                else if (prev_word_reg)
                begin
                    flag_next  = 1'b0;
                    state_next = ST_EMIT_MK;
                end
                else
                begin
                    best_next  = '0;
                    idx_next   = '0;
                    state_next = ST_M_RD;
                end
            end
            ST_M_RD:
            begin
                ram_raddr = row(text_list_reg, idx_reg);
                if (idx_reg < count_reg[text_list_reg])
                begin
                    state_next = ST_M_CHK;
                end
                else
                begin
                    flag_next = (best_reg != 6'd0);
                    if (best_reg != 6'd0)
                    begin
                        run_rem_next = best_reg - 6'd1;
                    end
                    state_next = ST_EMIT_MK;
                end
            end
            ST_M_CHK:
            begin
                // Keep the longest word with a non-word unit or text end behind it.
                ok = rd_len != 6'd0 && rd_len <= MAX_WORD_LEN && rd_len <= win_fill_reg &&
                     rd_len > best_reg && cmp_eq &&
                     ((rd_len < win_fill_reg) ? !is_word(win_at_len) : at_end_reg);
                if (ok)
                begin
                    best_next = rd_len;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = ST_M_RD;
            end
            ST_EMIT_MK:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next                = '0;
                    out_data_next.result_kind    = KIND_MASK;
                    out_data_next.code_unit_out  = win_reg[0];
                    out_data_next.protected_flag = flag_reg;
                    out_data_next.last           = at_end_reg && (win_fill_reg == WFW'(1));
                    prev_word_next               = is_word(win_reg[0]);
                    for (int k = 0; k < WIN - 1; k++)
                    begin
                        win_next[k] = win_reg[k+1];
                    end
                    win_fill_next = win_fill_reg - WFW'(1);
                    if (at_end_reg && win_fill_reg > WFW'(1))
                    begin
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        if (at_end_reg)
                        begin
                            active_next    = 1'b0;
                            win_fill_next  = '0;
                            run_rem_next   = '0;
                            prev_word_next = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_ST:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next              = '0;
                    out_data_next.result_kind  = KIND_STATUS;
                    out_data_next.status       = status_reg;
                    out_data_next.entry_count  = 7'(count_reg[list_reg]);
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            list_reg      <= 1'b0;
            text_list_reg <= 1'b0;
            len_reg       <= '0;
            best_reg      <= '0;
            status_reg    <= STAT_OK;
            flag_reg      <= 1'b0;
            at_end_reg    <= 1'b0;
            for (int l = 0; l < LIST_COUNT; l++)
            begin
                count_reg[l] <= '0;
            end
            fill_reg      <= '0;
            trim_reg      <= '0;
            ovf_reg       <= 1'b0;
            win_fill_reg  <= '0;
            run_rem_reg   <= '0;
            prev_word_reg <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            list_reg      <= list_next;
            text_list_reg <= text_list_next;
            len_reg       <= len_next;
            best_reg      <= best_next;
            status_reg    <= status_next;
            flag_reg      <= flag_next;
            at_end_reg    <= at_end_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            trim_reg      <= trim_next;
            ovf_reg       <= ovf_next;
            win_fill_reg  <= win_fill_next;
            run_rem_reg   <= run_rem_next;
            prev_word_reg <= prev_word_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: staging characters, text window and the output word.
    always_ff @(posedge clk)
    begin
        stage_reg    <= stage_next;
        win_reg      <= win_next;
        out_data_reg <= out_data_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("result word changed while stalled");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] <= MAX_WORDS)
        else $error("dictionary count above capacity");

    a_win_max: assert property (@(posedge clk) disable iff (!rst_n)
        win_fill_reg <= WIN)
        else $error("text window overfilled");

    a_run_active: assert property (@(posedge clk) disable iff (!rst_n)
        run_rem_reg != 6'd0 |-> active_reg)
        else $error("protected run outside a text run");
endmodule
